// ===== src/m3inv_pkg.sv =====
package m3inv_pkg;

   localparam int ELEM_W      = 32;
   localparam int FRAC_BITS   = 16;
   localparam int THR_W       = 31;
   localparam logic [THR_W-1:0] THR_RESET = 31'd7;
   // cofactor: 64-bit products, one more bit for the difference
   localparam int ADJ_W       = 2 * ELEM_W + 1;
   // determinant: cofactor times element, three terms summed
   localparam int DET_W       = ADJ_W + ELEM_W + 2;
   localparam int QUO_W       = 34;
   localparam int FIFO_DEPTH  = 4;

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic signed [ADJ_W-1:0]  adj_type;
   typedef logic signed [DET_W-1:0]  det_type;

   // one classified matrix handed from the front part to the back part
   typedef struct packed {
      logic            singular;
      logic            det_neg;
      logic [DET_W-1:0] det_mag;
      adj_type [8:0]   adj;
   } job_type;

endpackage

// ===== src/m3inv_front.sv =====
module m3inv_front #(
   parameter int FRAC = m3inv_pkg::FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_stall,
   input  m3inv_pkg::elem_type [8:0]     in_m,
   input  logic [m3inv_pkg::THR_W-1:0]   thr,
   output logic                          out_valid,
   input  logic                          out_stall,
   output m3inv_pkg::job_type            out_job
);

   localparam int EW  = m3inv_pkg::ELEM_W;
   localparam int AW  = m3inv_pkg::ADJ_W;
   localparam int DW  = m3inv_pkg::DET_W;
   // cofactor split for the determinant: signed upper part, unsigned lower part
   localparam int LW  = EW + 1;
   localparam int HPW = 2 * EW;
   localparam int LPW = LW + 1 + EW;

   // stage 1: 2x2 products, stage 2: cofactors, stage 3: partial products of
   // the first-row expansion, stage 4: det sum, stage 5: magnitude and
   // singular test
   logic [4:0] v_ff, v_in;
   logic adv;

   logic signed [2*EW-1:0] p_ff [18], p_in [18];
   m3inv_pkg::elem_type r1_ff [3], r1_in [3];
   m3inv_pkg::adj_type a2_ff [9], a2_in [9];
   m3inv_pkg::elem_type r2_ff [3], r2_in [3];
   m3inv_pkg::adj_type a3_ff [9], a3_in [9];
   logic signed [HPW-1:0] ph3_ff [3], ph3_in [3];
   logic signed [LPW-1:0] pl3_ff [3], pl3_in [3];
   m3inv_pkg::adj_type a4_ff [9], a4_in [9];
   logic signed [DW-1:0] det4_ff, det4_in;
   m3inv_pkg::job_type j5_ff, j5_in;

   logic [DW-1:0] dmag, thr_sh;

   assign adv      = !(v_ff[4] && out_stall);
   assign in_stall = !adv;

   function automatic logic signed [2*EW-1:0] mul(input m3inv_pkg::elem_type a,
                                                  input m3inv_pkg::elem_type b);
      mul = (2*EW)'(a) * (2*EW)'(b);
   endfunction

   always_comb begin
      // pairs (a*d, b*c) per cofactor, see adjugate layout
      p_in[0]  = mul(in_m[4], in_m[8]); p_in[1]  = mul(in_m[5], in_m[7]);
      p_in[2]  = mul(in_m[1], in_m[8]); p_in[3]  = mul(in_m[2], in_m[7]);
      p_in[4]  = mul(in_m[1], in_m[5]); p_in[5]  = mul(in_m[2], in_m[4]);
      p_in[6]  = mul(in_m[3], in_m[8]); p_in[7]  = mul(in_m[5], in_m[6]);
      p_in[8]  = mul(in_m[0], in_m[8]); p_in[9]  = mul(in_m[2], in_m[6]);
      p_in[10] = mul(in_m[0], in_m[5]); p_in[11] = mul(in_m[2], in_m[3]);
      p_in[12] = mul(in_m[3], in_m[7]); p_in[13] = mul(in_m[4], in_m[6]);
      p_in[14] = mul(in_m[0], in_m[7]); p_in[15] = mul(in_m[1], in_m[6]);
      p_in[16] = mul(in_m[0], in_m[4]); p_in[17] = mul(in_m[1], in_m[3]);
      for (int i = 0; i < 3; i++) r1_in[i] = in_m[i];
      for (int k = 0; k < 9; k++) begin
         if (k == 1 || k == 3 || k == 5 || k == 7) begin
            a2_in[k] = AW'(p_ff[2*k+1]) - AW'(p_ff[2*k]);
         end else begin
            a2_in[k] = AW'(p_ff[2*k]) - AW'(p_ff[2*k+1]);
         end
      end
      r2_in = r1_ff;
      a3_in = a2_ff;
      for (int i = 0; i < 3; i++) begin
         ph3_in[i] = HPW'(signed'(a2_ff[3*i][AW-1:LW])) * HPW'(r2_ff[i]);
         pl3_in[i] = LPW'(signed'({1'b0, a2_ff[3*i][LW-1:0]})) * LPW'(r2_ff[i]);
      end
      a4_in = a3_ff;
      det4_in = '0;
      for (int i = 0; i < 3; i++) begin
         det4_in = det4_in + (DW'(ph3_ff[i]) << LW) + DW'(pl3_ff[i]);
      end
      dmag = det4_ff[DW-1] ? DW'(-det4_ff) : DW'(det4_ff);
      thr_sh = DW'(thr) << (2 * FRAC);
      j5_in.det_neg  = det4_ff[DW-1];
      j5_in.det_mag  = dmag;
      j5_in.singular = (dmag == '0) || (dmag < thr_sh);
      for (int k = 0; k < 9; k++) j5_in.adj[k] = a4_ff[k];
      v_in = {v_ff[3:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff    <= p_in;
         r1_ff   <= r1_in;
         a2_ff   <= a2_in;
         r2_ff   <= r2_in;
         a3_ff   <= a3_in;
         ph3_ff  <= ph3_in;
         pl3_ff  <= pl3_in;
         a4_ff   <= a4_in;
         det4_ff <= det4_in;
         j5_ff   <= j5_in;
      end
   end

   assign out_valid = v_ff[4];
   assign out_job   = j5_ff;

   property p_hold;
      @(posedge clock) disable iff (reset) (v_ff[4] && out_stall) |=> v_ff[4];
   endproperty
   a_hold: assert property (p_hold) else $error("front output dropped");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      in_stall |-> (v_ff[4] && out_stall)) else $error("spurious stall");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      (v_ff[4] && j5_ff.det_mag == '0) |-> j5_ff.singular)
      else $error("zero det not singular");

endmodule

// ===== src/m3inv_fifo.sv =====
module m3inv_fifo #(
   parameter int DEPTH = m3inv_pkg::FIFO_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_stall,
   input  m3inv_pkg::job_type in_job,
   output logic               out_valid,
   input  logic               out_stall,
   output m3inv_pkg::job_type out_job
);

   localparam int AW = $clog2(DEPTH);

   m3inv_pkg::job_type mem [DEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0]   cnt_ff, cnt_in;
   logic push, pop;

   assign in_stall  = (cnt_ff == (AW+1)'(DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;
   assign out_job   = mem[rp_ff];
   assign cnt_in    = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1;
         if (pop)  rp_ff <= (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem[wp_ff] <= in_job;
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AW+1)'(DEPTH)) else $error("fifo count overflow");
   a_inc: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> cnt_ff == $past(cnt_ff) + 1'b1) else $error("count slip");
   a_dec: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> cnt_ff == $past(cnt_ff) - 1'b1) else $error("count slip");

endmodule

// ===== src/m3inv_back.sv =====
module m3inv_back #(
   parameter int FRAC = m3inv_pkg::FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_stall,
   input  m3inv_pkg::job_type        in_job,
   output logic                      out_valid,
   input  logic                      out_stall,
   output m3inv_pkg::elem_type [8:0] out_r,
   output logic                      out_singular
);

   // restoring divider, one quotient bit per stage, nine lanes side by side.
   // quotient below 2^(QW) is all that matters; larger saturates.
   localparam int AW = m3inv_pkg::ADJ_W;
   localparam int DW = m3inv_pkg::DET_W;
   localparam int QW = m3inv_pkg::QUO_W;
   localparam int NW = AW + 2 * FRAC;       // numerator width
   localparam int NS = QW;                  // stages
   localparam int RW = DW + 1;              // remainder width

   typedef struct packed {
      logic [NW-1:0] num;
      logic          neg;
      logic [RW-1:0] rem;
      logic [QW-1:0] q;
      logic          ovf;
   } lane_type;

   logic [NS:0] v_ff;
   logic adv;
   lane_type ln_ff [NS+1][9];
   logic [DW-1:0] den_ff [NS+1];
   logic sing_ff [NS+1];
   lane_type ln_in [NS+1][9];
   m3inv_pkg::elem_type res [9];

   assign adv      = !(v_ff[NS] && out_stall);
   assign in_stall = !adv;

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         logic [AW-1:0] amag;
         logic [NW-1:0] n;
         logic [RW-1:0] hi;
         amag = in_job.adj[k][AW-1] ? AW'(-in_job.adj[k]) : AW'(in_job.adj[k]);
         n = NW'(amag) << (2 * FRAC);
         ln_in[0][k].neg = in_job.adj[k][AW-1] ^ in_job.det_neg;
         // bits above the top QW of quotient: precompare for overflow
         hi = RW'(n >> QW);
         ln_in[0][k].ovf = (hi >= RW'(in_job.det_mag));
         ln_in[0][k].rem = hi;
         ln_in[0][k].num = n;
         ln_in[0][k].q   = '0;
      end
      for (int s = 0; s < NS; s++) begin
         for (int k = 0; k < 9; k++) begin
            logic [RW-1:0] t;
            t = {ln_ff[s][k].rem[RW-2:0], ln_ff[s][k].num[QW-1-s]};
            ln_in[s+1][k] = ln_ff[s][k];
            if (t >= RW'(den_ff[s])) begin
               ln_in[s+1][k].rem = t - RW'(den_ff[s]);
               ln_in[s+1][k].q   = {ln_ff[s][k].q[QW-2:0], 1'b1};
            end else begin
               ln_in[s+1][k].rem = t;
               ln_in[s+1][k].q   = {ln_ff[s][k].q[QW-2:0], 1'b0};
            end
         end
      end
      for (int k = 0; k < 9; k++) begin
         lane_type l;
         l = ln_ff[NS][k];
         if (sing_ff[NS]) begin
            res[k] = '0;
         end else if (!l.neg) begin
            res[k] = (l.ovf || l.q > QW'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : l.q[31:0];
         end else begin
            res[k] = (l.ovf || l.q > QW'(32'h80000000)) ? 32'h80000000
                                                         : 32'(-l.q[31:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NS-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ln_ff[0]   <= ln_in[0];
         den_ff[0]  <= in_job.det_mag;
         sing_ff[0] <= in_job.singular;
         for (int s = 0; s < NS; s++) begin
            ln_ff[s+1]   <= ln_in[s+1];
            den_ff[s+1]  <= den_ff[s];
            sing_ff[s+1] <= sing_ff[s];
         end
      end
   end

   assign out_valid    = v_ff[NS];
   assign out_singular = sing_ff[NS];
   always_comb for (int k = 0; k < 9; k++) out_r[k] = res[k];

   a_sing: assert property (@(posedge clock) disable iff (reset)
      (v_ff[NS] && sing_ff[NS]) |-> (out_r[0] == '0 && out_r[8] == '0))
      else $error("singular result not zero");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (v_ff[NS] && out_stall) |=> v_ff[NS]) else $error("result dropped");
   a_st: assert property (@(posedge clock) disable iff (reset)
      in_stall |-> v_ff[NS]) else $error("spurious stall");

endmodule

// ===== src/matrix3_inverse_top.sv =====
// channel   | ports                       | accepted when
// req       | req_valid, req_stall, m*    | req_valid && !req_stall
// rsp       | rsp_valid, rsp_stall, r*    | rsp_valid && !rsp_stall
// csr       | csr_we, csr_wdata           | csr_we
// One matrix accepted per cycle while req_stall is low. Five determinant stages,
// then the queue, then 35 register stages of the bit-per-stage divider.
// Reset is synchronous and clears valids and the threshold to 7. A stalled
// result holds the divider; the queue absorbs the front until it fills.
module matrix3_inverse_top #(
   parameter int FRAC_BITS = m3inv_pkg::FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [31:0]            req_m00, req_m01, req_m02,
   input  logic signed [31:0]            req_m10, req_m11, req_m12,
   input  logic signed [31:0]            req_m20, req_m21, req_m22,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [31:0]            rsp_r00, rsp_r01, rsp_r02,
   output logic signed [31:0]            rsp_r10, rsp_r11, rsp_r12,
   output logic signed [31:0]            rsp_r20, rsp_r21, rsp_r22,
   output logic                          rsp_singular,
   input  logic                          csr_we,
   input  logic [30:0]                   csr_wdata
);

   logic [m3inv_pkg::THR_W-1:0] thr_ff;
   m3inv_pkg::elem_type [8:0] m, r;
   m3inv_pkg::job_type fj, qj;
   logic f2q_valid, f2q_stall, q2b_valid, q2b_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= m3inv_pkg::THR_RESET;
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   assign m = {req_m22, req_m21, req_m20, req_m12, req_m11, req_m10,
               req_m02, req_m01, req_m00};

   m3inv_front #(.FRAC(FRAC_BITS)) u_front (
      .clock, .reset, .in_valid(req_valid), .in_stall(req_stall), .in_m(m),
      .thr(thr_ff), .out_valid(f2q_valid), .out_stall(f2q_stall), .out_job(fj));

   m3inv_fifo u_fifo (
      .clock, .reset, .in_valid(f2q_valid), .in_stall(f2q_stall), .in_job(fj),
      .out_valid(q2b_valid), .out_stall(q2b_stall), .out_job(qj));

   m3inv_back #(.FRAC(FRAC_BITS)) u_back (
      .clock, .reset, .in_valid(q2b_valid), .in_stall(q2b_stall), .in_job(qj),
      .out_valid(rsp_valid), .out_stall(rsp_stall), .out_r(r),
      .out_singular(rsp_singular));

   assign {rsp_r22, rsp_r21, rsp_r20, rsp_r12, rsp_r11, rsp_r10,
           rsp_r02, rsp_r01, rsp_r00} = r;

endmodule

// ===== test/tb_matrix3_inverse_top.sv =====
module tb_matrix3_inverse_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam m3inv_pkg::elem_type ONE  = 32'sh0001_0000;
   localparam m3inv_pkg::elem_type MAXV = 32'sh7FFF_FFFF;
   localparam m3inv_pkg::elem_type MINV = 32'sh8000_0000;
   localparam int       NO_WRITE = -1;
   localparam int       SETTLE_CYCLES = 60;

   typedef m3inv_pkg::elem_type vec9_type [9];

   typedef struct {
      vec9_type r;
      logic     singular;
   } inverse_type;

   typedef struct {
      int          new_thr;
      vec9_type    m;
      bit          typed;
      inverse_type want;
   } dir_row_type;

   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic       req_stall;
   m3inv_pkg::elem_type req_m [9];
   logic       rsp_valid;
   logic       rsp_stall = 0;
   m3inv_pkg::elem_type rsp_r [9];
   logic       rsp_singular;
   logic       csr_we = 0;
   logic [30:0] csr_wdata = '0;

   logic [30:0]  threshold = m3inv_pkg::THR_RESET;
   inverse_type  pending_inverses [$];
   int           err_count = 0;
   bit           no_idle = 0;
   int           stall_left = 0;
   dir_row_type  dir_tab [$];

   initial foreach (req_m[i]) req_m[i] = '0;

   always #5 clock = ~clock;

   matrix3_inverse_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_m00(req_m[0]), .req_m01(req_m[1]), .req_m02(req_m[2]),
      .req_m10(req_m[3]), .req_m11(req_m[4]), .req_m12(req_m[5]),
      .req_m20(req_m[6]), .req_m21(req_m[7]), .req_m22(req_m[8]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_r00(rsp_r[0]), .rsp_r01(rsp_r[1]), .rsp_r02(rsp_r[2]),
      .rsp_r10(rsp_r[3]), .rsp_r11(rsp_r[4]), .rsp_r12(rsp_r[5]),
      .rsp_r20(rsp_r[6]), .rsp_r21(rsp_r[7]), .rsp_r22(rsp_r[8]),
      .rsp_singular(rsp_singular),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // exact adjugate / determinant, truncating divide, 32-bit saturation
   function automatic inverse_type invert_matrix(vec9_type a, logic [30:0] thr);
      logic signed [127:0] m [9];
      logic signed [127:0] adj [9];
      logic signed [127:0] det;
      logic [127:0] det_mag, adj_mag, thr_wide, quo;
      logic neg;
      inverse_type res;
      foreach (a[i]) m[i] = a[i];
      adj[0] =   m[4] * m[8] - m[5] * m[7];
      adj[1] = -(m[1] * m[8] - m[2] * m[7]);
      adj[2] =   m[1] * m[5] - m[2] * m[4];
      adj[3] = -(m[3] * m[8] - m[5] * m[6]);
      adj[4] =   m[0] * m[8] - m[2] * m[6];
      adj[5] = -(m[0] * m[5] - m[2] * m[3]);
      adj[6] =   m[3] * m[7] - m[4] * m[6];
      adj[7] = -(m[0] * m[7] - m[1] * m[6]);
      adj[8] =   m[0] * m[4] - m[1] * m[3];
      det = adj[0] * m[0] + adj[3] * m[1] + adj[6] * m[2];
      det_mag = (det < 0) ? -det : det;
      thr_wide = {97'b0, thr};
      thr_wide = thr_wide << (2 * m3inv_pkg::FRAC_BITS);
      res.singular = (det == 0) || (det_mag < thr_wide);
      foreach (res.r[i]) begin
         if (res.singular) begin
            res.r[i] = '0;
         end else begin
            adj_mag = (adj[i] < 0) ? -adj[i] : adj[i];
            quo = (adj_mag << (2 * m3inv_pkg::FRAC_BITS)) / det_mag;
            neg = (adj[i] < 0) ^ (det < 0);
            if (!neg)
               res.r[i] = (quo > 128'h7FFF_FFFF) ? MAXV
                                                 : m3inv_pkg::elem_type'(quo[31:0]);
            else
               res.r[i] = (quo > 128'h8000_0000) ? MINV
                                                 : m3inv_pkg::elem_type'(-quo[31:0]);
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, longint want, longint got);
      $display("%0t mismatch %s: expected %0h got %0h", $realtime, what, want, got);
      err_count++;
   endtask

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // result side: random stall, check each transaction against the oldest prediction
   always @(posedge clock) begin
      inverse_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_inverses.size() == 0) begin
            report_mismatch("unexpected transaction", 0, rsp_r[0]);
         end else begin
            want = pending_inverses.pop_front();
            foreach (rsp_r[i])
               if (rsp_r[i] !== want.r[i])
                  report_mismatch($sformatf("r%0d%0d", i / 3, i % 3), want.r[i], rsp_r[i]);
            if (rsp_singular !== want.singular)
               report_mismatch("singular", want.singular, rsp_singular);
         end
      end
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 99) < 30) begin
         stall_left <= ($urandom_range(0, 99) < 93) ? $urandom_range(0, 3)
                                                    : $urandom_range(15, 50);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_matrix(vec9_type a, bit typed = 0, inverse_type want = '{default: 0});
      inverse_type pred;
      int gap;
      req_valid <= 1'b1;
      foreach (a[i]) req_m[i] <= a[i];
      do @(posedge clock); while (req_stall);
      pred = invert_matrix(a, threshold);
      if (typed) begin
         // hand-computed value must agree with the predictor too
         foreach (want.r[i])
            if (want.r[i] !== pred.r[i])
               report_mismatch("table entry", want.r[i], pred.r[i]);
         if (want.singular !== pred.singular)
            report_mismatch("table singular", want.singular, pred.singular);
         pending_inverses.push_back(want);
      end else begin
         pending_inverses.push_back(pred);
      end
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_inverses.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(logic [30:0] value);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      threshold = value;
   endtask

   function automatic m3inv_pkg::elem_type small_val(int range);
      return m3inv_pkg::elem_type'($urandom_range(0, 2 * range))
             - m3inv_pkg::elem_type'(range);
   endfunction

   function automatic vec9_type random_matrix();
      vec9_type a;
      int kind;
      kind = $urandom_range(0, 9);
      foreach (a[i]) begin
         case (kind) inside
            [0:1]: a[i] = m3inv_pkg::elem_type'($urandom());
            [2:6]: a[i] = small_val(4 * ONE);
            7: a[i] = small_val(2 * ONE);
            8: a[i] = small_val($urandom_range(1, 64));
            default: begin
               case ($urandom_range(0, 5))
                  0: a[i] = MAXV;
                  1: a[i] = MINV;
                  2: a[i] = '0;
                  3: a[i] = ONE;
                  4: a[i] = -ONE;
                  default: a[i] = m3inv_pkg::elem_type'($urandom());
               endcase
            end
         endcase
      end
      if (kind == 6) begin
         // diagonal dominance: well conditioned
         a[0] = a[0] + 16 * ONE;
         a[4] = a[4] - 16 * ONE;
         a[8] = a[8] + 16 * ONE;
      end
      if (kind == 7) begin
         // linearly dependent last row: determinant exactly zero
         for (int c = 0; c < 3; c++) a[6 + c] = a[c] + a[3 + c];
      end
      return a;
   endfunction

   function automatic dir_row_type dir_row(int new_thr, vec9_type m, bit typed = 0,
                                           bit sing = 0, vec9_type r = '{default: 0});
      dir_row_type row;
      row.new_thr = new_thr;
      row.m = m;
      row.typed = typed;
      row.want.r = r;
      row.want.singular = sing;
      return row;
   endfunction

   initial begin
      vec9_type z;
      z = '{default: 0};
      dir_tab = '{
         dir_row(NO_WRITE, '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}, 1, 0,
                 '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}),
         dir_row(NO_WRITE, z, 1, 1, z),
         dir_row(NO_WRITE, '{default: MAXV}, 1, 1, z),
         dir_row(NO_WRITE, '{default: MINV}, 1, 1, z),
         dir_row(NO_WRITE, '{2 * ONE, 0, 0, 0, 2 * ONE, 0, 0, 0, 2 * ONE}, 1, 0,
                 '{ONE / 2, 0, 0, 0, ONE / 2, 0, 0, 0, ONE / 2}),
         dir_row(NO_WRITE, '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}, 1, 0,
                 '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}),
         dir_row(NO_WRITE, '{MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV}),
         dir_row(NO_WRITE, '{MINV, 0, 0, 0, MINV, 0, 0, 0, MINV}),
         dir_row(NO_WRITE, '{1, 0, 0, 0, 1, 0, 0, 0, 1}, 1, 1, z),
         dir_row(NO_WRITE, '{MAXV, MINV, 0, 0, MAXV, MINV, MINV, 0, MAXV}),
         dir_row(NO_WRITE, '{ONE, 2 * ONE, 3 * ONE, 0, ONE, 4 * ONE, 0, 0, ONE}),
         dir_row(NO_WRITE, '{0, ONE, 0, 0, 0, ONE, ONE, 0, 0}),
         dir_row(NO_WRITE, '{ONE / 2, 0, 0, 0, ONE / 2, 0, 0, 0, ONE / 2}, 1, 0,
                 '{2 * ONE, 0, 0, 0, 2 * ONE, 0, 0, 0, 2 * ONE}),
         dir_row(NO_WRITE, '{256 * ONE, 0, 0, 0, 256 * ONE, 0, 0, 0, 256 * ONE}, 1, 0,
                 '{256, 0, 0, 0, 256, 0, 0, 0, 256}),
         dir_row(NO_WRITE, '{256, 0, 0, 0, 256, 0, 0, 0, 256}, 1, 1, z),
         dir_row(NO_WRITE, '{4096 * ONE, 5, -7, 0, 4096 * ONE, 0, 3, 0, -4096 * ONE}),
         // zero threshold: tiny determinant passes and quotients saturate
         dir_row(0, '{1, 0, 0, 0, 1, 0, 0, 0, 1}, 1, 0,
                 '{MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV}),
         dir_row(NO_WRITE, '{-1, 0, 0, 0, 1, 0, 0, 0, 1}, 1, 0,
                 '{MINV, 0, 0, 0, MAXV, 0, 0, 0, MAXV}),
         dir_row(NO_WRITE, z, 1, 1, z),
         dir_row(NO_WRITE, '{default: MINV}, 1, 1, z),
         // largest threshold
         dir_row(32'h7FFF_FFFF, '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}, 1, 1, z),
         dir_row(NO_WRITE, '{MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV}),
         dir_row(NO_WRITE, '{MINV, 0, 0, 0, MAXV, 0, 0, 0, MINV})
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[k]) begin
         if (dir_tab[k].new_thr != NO_WRITE) write_threshold(dir_tab[k].new_thr[30:0]);
         send_matrix(dir_tab[k].m, dir_tab[k].typed, dir_tab[k].want);
      end

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: write_threshold(m3inv_pkg::THR_RESET);
            1: write_threshold('0);
            2: write_threshold(31'd1);
            3: write_threshold(31'h7FFF_FFFF);
            4: write_threshold(31'($urandom_range(0, 1 << 20)));
            default: write_threshold(31'($urandom()));
         endcase
         // one phase at full rate with no idling on either side
         no_idle = (phase == 2);
         repeat (110) send_matrix(random_matrix());
      end
      no_idle = 0;

      drain();
      if (err_count == 0)
         $display("[matrix3_inverse_top] OK");
      else
         $display("[matrix3_inverse_top] ERROR");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("[matrix3_inverse_top] ERROR");
      $finish;
   end

endmodule
